@@ src/cle_pkg.sv @@
// Shared types and constants for the console line editor.
// Depends on nothing; used by cle_line_ram and console_line_editor.
package cle_pkg;

    // Store geometry and field widths.
    localparam int LINE_DEPTH = 64;
    localparam int ADDR_W     = $clog2(LINE_DEPTH);
    localparam int LIMIT_W    = 7;
    localparam int LEN_W      = 6;
    localparam int BYTE_W     = 8;

    // Character codes the editor reacts to.
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_BS    = 8'h08;
    localparam logic [BYTE_W-1:0] CH_DEL   = 8'h7F;
    localparam logic [BYTE_W-1:0] CH_SP    = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TILDE = 8'h7E;

    // Reset value of the line limit register.
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(64);

    // Write request into the line store.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
    } cle_wr_t;

    // Read request into the line store.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } cle_rd_t;

endpackage

@@ src/cle_line_ram.sv @@
// Line store: one write port and one read port, read data registered.
// Depends on cle_pkg.
module cle_line_ram (
    input  logic                        clk,
    input  cle_pkg::cle_wr_t            wr,
    input  cle_pkg::cle_rd_t            rd,
    output logic [cle_pkg::BYTE_W-1:0]  rd_data
);

    logic [cle_pkg::BYTE_W-1:0] mem [cle_pkg::LINE_DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // Read port; the data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_data <= mem[rd.addr];
        end
    end

endmodule

@@ src/console_line_editor.sv @@
// Console line editor: each input byte is held in byte_reg and decoded; result beats are registered.
// A printable byte gives one echo beat, a dropped byte none, an erase on a non-empty line three.
// A line end on n stored bytes (n > 0) gives an LF echo, then n line beats read one per cycle
// from the store while out_ready holds. A new byte is taken only once the block is idle again.
// Reset clears the fill position and sets the line limit to 64; store contents stay undefined.
// Depends on cle_pkg and cle_line_ram.
module console_line_editor (
    input  logic                               clk,
    input  logic                               rst_n,
    // Configuration write channel (line limit).
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [cle_pkg::LIMIT_W-1:0]        cfg_data,
    // Received byte channel.
    input  logic                               rx_valid,
    output logic                               rx_ready,
    input  logic [cle_pkg::BYTE_W-1:0]         rx_byte,
    // Result channel.
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               dest,
    output logic [cle_pkg::BYTE_W-1:0]         data_byte,
    output logic [cle_pkg::LEN_W-1:0]          line_length,
    output logic                               last
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_ERASE_SP,
        ST_ERASE_BS,
        ST_LINE
    } state_t;

    state_t                        state_reg, state_next;
    logic [cle_pkg::LIMIT_W-1:0]   limit_reg, limit_next;
    logic [cle_pkg::ADDR_W-1:0]    fill_reg, fill_next;
    logic [cle_pkg::ADDR_W-1:0]    idx_reg, idx_next;
    logic [cle_pkg::BYTE_W-1:0]    byte_reg, byte_next;
    logic                          out_valid_reg, out_valid_next;
    logic                          dest_reg, dest_next;
    logic [cle_pkg::BYTE_W-1:0]    data_reg, data_next;
    logic [cle_pkg::LEN_W-1:0]     len_reg, len_next;
    logic                          last_reg, last_next;

    cle_pkg::cle_wr_t              ram_wr;
    cle_pkg::cle_rd_t              ram_rd;
    logic [cle_pkg::BYTE_W-1:0]    ram_rd_data;

    logic [cle_pkg::LIMIT_W-1:0]   lim_clip;
    logic [cle_pkg::LIMIT_W-1:0]   capacity;
    logic                          has_room;
    logic                          is_eol;
    logic                          is_erase;
    logic                          is_print;
    logic                          can_push;
    logic                          line_end;

    cle_line_ram u_ram (
        .clk     (clk),
        .wr      (ram_wr),
        .rd      (ram_rd),
        .rd_data (ram_rd_data)
    );

    // Capacity is min(limit, depth) - 1, and zero for a zero limit.
    always_comb
    begin
        lim_clip = (limit_reg > cle_pkg::LIMIT_W'(cle_pkg::LINE_DEPTH))
                 ? cle_pkg::LIMIT_W'(cle_pkg::LINE_DEPTH) : limit_reg;
        capacity = (limit_reg == '0) ? '0 : lim_clip - 1'b1;
        has_room = cle_pkg::LIMIT_W'(fill_reg) < capacity;
    end

    // Byte classes of the held input byte.
    assign is_eol   = (byte_reg == cle_pkg::CH_CR) || (byte_reg == cle_pkg::CH_LF);
    assign is_erase = (byte_reg == cle_pkg::CH_DEL) || (byte_reg == cle_pkg::CH_BS);
    assign is_print = (byte_reg >= cle_pkg::CH_SP) && (byte_reg <= cle_pkg::CH_TILDE);

    // The output register can take a new beat when empty or draining now.
    assign can_push = !out_valid_reg || out_ready;
    assign line_end = (idx_reg == fill_reg - 1'b1);

    // Next-state and store access logic.
    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        idx_next       = idx_reg;
        byte_next      = byte_reg;
        dest_next      = dest_reg;
        data_next      = data_reg;
        len_next       = len_reg;
        last_next      = last_reg;
        limit_next     = limit_reg;
        out_valid_next = out_valid_reg && !out_ready;
        ram_wr         = '0;
        ram_rd         = '0;

        if (cfg_valid)
        begin
            limit_next = cfg_data;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (rx_valid)
                begin
                    byte_next  = rx_byte;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                priority if (is_eol)
                begin
                    if (fill_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (can_push)
                    begin
                        // Echo LF and fetch the first line byte.
                        out_valid_next = 1'b1;
                        dest_next      = 1'b0;
                        data_next      = cle_pkg::CH_LF;
                        len_next       = '0;
                        last_next      = 1'b0;
                        idx_next       = '0;
                        ram_rd.en      = 1'b1;
                        ram_rd.addr    = '0;
                        state_next     = ST_LINE;
                    end
                end
                else if (is_erase)
                begin
                    if (fill_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (can_push)
                    begin
                        out_valid_next = 1'b1;
                        dest_next      = 1'b0;
                        data_next      = cle_pkg::CH_BS;
                        len_next       = '0;
                        last_next      = 1'b0;
                        fill_next      = fill_reg - 1'b1;
                        state_next     = ST_ERASE_SP;
                    end
                end
                else if (is_print && has_room)
                begin
                    if (can_push)
                    begin
                        out_valid_next = 1'b1;
                        dest_next      = 1'b0;
                        data_next      = byte_reg;
                        len_next       = '0;
                        last_next      = 1'b1;
                        ram_wr.en      = 1'b1;
                        ram_wr.addr    = fill_reg;
                        ram_wr.data    = byte_reg;
                        fill_next      = fill_reg + 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
                else
                begin
                    // Non-printable bytes and bytes beyond capacity are dropped.
                    state_next = ST_IDLE;
                end
            end
            ST_ERASE_SP:
            begin
                if (can_push)
                begin
                    out_valid_next = 1'b1;
                    data_next      = cle_pkg::CH_SP;
                    state_next     = ST_ERASE_BS;
                end
            end
            ST_ERASE_BS:
            begin
                if (can_push)
                begin
                    out_valid_next = 1'b1;
                    data_next      = cle_pkg::CH_BS;
                    last_next      = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_LINE:
            begin
                // Read data belongs to idx_reg; the next read is issued on each beat but the last.
                if (can_push)
                begin
                    out_valid_next = 1'b1;
                    dest_next      = 1'b1;
                    data_next      = ram_rd_data;
                    len_next       = cle_pkg::LEN_W'(fill_reg);
                    last_next      = line_end;
                    if (line_end)
                    begin
                        fill_next  = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next    = idx_reg + 1'b1;
                        ram_rd.en   = 1'b1;
                        ram_rd.addr = idx_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, counters and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            limit_reg     <= cle_pkg::LIMIT_RESET;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            limit_reg     <= limit_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        byte_reg <= byte_next;
        dest_reg <= dest_next;
        data_reg <= data_next;
        len_reg  <= len_next;
        last_reg <= last_next;
    end

    assign cfg_ready   = 1'b1;
    assign rx_ready    = (state_reg == ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign dest        = dest_reg;
    assign data_byte   = data_reg;
    assign line_length = len_reg;
    assign last        = last_reg;

    // A line beat always carries a nonzero length.
    a_line_len: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && dest) |-> (line_length != '0))
        else $error("line beat with zero length");

    // Echo beats carry a zero length.
    a_echo_len: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !dest) |-> (line_length == '0))
        else $error("echo beat with nonzero length");

    // Line read-out only runs over a non-empty line.
    a_line_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LINE) |-> (fill_reg != '0))
        else $error("line read-out with empty line");

    // The read-out index stays below the fill position.
    a_line_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LINE) |-> (idx_reg < fill_reg))
        else $error("read-out index beyond fill position");

endmodule

@@ tb/tb_console_line_editor.sv @@
// Self-checking testbench for console_line_editor: a directed table, then random console traffic.
// Expected beats come from an in-bench line editor model, or the typed-in beats of fixed table rows;
// each output beat is compared with them. Depends on cle_pkg and the console_line_editor RTL.
module tb_console_line_editor;
    timeunit 1ns;
    timeprecision 1ps;

    // Idle time before a register write; the drain time at the end is twice this.
    localparam int SETTLE = 16;
    // Input beats sent in each random phase.
    localparam int PHASE_BEATS = 48;

    // One output beat of the editor.
    typedef struct packed {
        logic                       dest;
        logic [cle_pkg::BYTE_W-1:0] data;
        logic [cle_pkg::LEN_W-1:0]  len;
        logic                       last;
    } res_t;

    // Kinds of rows in the directed table.
    typedef enum logic [1:0] {
        ROW_PRED,
        ROW_FIXED,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t                  kind;
        logic [cle_pkg::BYTE_W-1:0] val;
        logic [1:0]                 nfix;
        res_t                       fx0;
        res_t                       fx1;
        res_t                       fx2;
    } row_t;

    logic                         clk;
    logic                         rst_n     = 1'b0;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [cle_pkg::LIMIT_W-1:0]  cfg_data  = '0;
    logic                         rx_valid  = 1'b0;
    logic                         rx_ready;
    logic [cle_pkg::BYTE_W-1:0]   rx_byte   = '0;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    logic                         dest;
    logic [cle_pkg::BYTE_W-1:0]   data_byte;
    logic [cle_pkg::LEN_W-1:0]    line_length;
    logic                         last;

    // Model state of the line editor.
    logic [cle_pkg::LIMIT_W-1:0]  mdl_limit = cle_pkg::LIMIT_RESET;
    int                           mdl_fill  = 0;
    logic [cle_pkg::BYTE_W-1:0]   mdl_store [cle_pkg::LINE_DEPTH];

    res_t                line_expect [$];
    row_t                stim_table [$];
    int                  err_count = 0;
    int                  gap_pct   = 0;
    int                  stall_pct = 0;

    console_line_editor dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .rx_valid    (rx_valid),
        .rx_ready    (rx_ready),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .dest        (dest),
        .data_byte   (data_byte),
        .line_length (line_length),
        .last        (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #10_000_000;
        $display("[console_line_editor] ERROR");
        $finish;
    end

    function automatic res_t mk_res(input logic d, input logic [cle_pkg::BYTE_W-1:0] b,
                                    input logic [cle_pkg::LEN_W-1:0] l, input logic e);
        res_t r;
        r.dest = d;
        r.data = b;
        r.len  = l;
        r.last = e;
        return r;
    endfunction

    function automatic row_t mk_row(input row_kind_t k, input logic [cle_pkg::BYTE_W-1:0] v,
                                    input logic [1:0] n, input res_t a, input res_t b,
                                    input res_t c);
        row_t r;
        r.kind = k;
        r.val  = v;
        r.nfix = n;
        r.fx0  = a;
        r.fx1  = b;
        r.fx2  = c;
        return r;
    endfunction

    // Number of bytes the line can hold under the current limit.
    function automatic int line_cap();
        int lim;
        lim = int'(mdl_limit);
        if (lim == 0)
            return 0;
        if (lim > cle_pkg::LINE_DEPTH)
            lim = cle_pkg::LINE_DEPTH;
        return lim - 1;
    endfunction

    // Applies one received byte to the model and queues the beats it causes.
    function automatic int predict_edit(input logic [cle_pkg::BYTE_W-1:0] c);
        int n;
        n = 0;
        if (c == cle_pkg::CH_CR || c == cle_pkg::CH_LF)
        begin
            // A line end on an empty line is dropped.
            if (mdl_fill != 0)
            begin
                line_expect.push_back(mk_res(1'b0, cle_pkg::CH_LF, '0, 1'b0));
                for (int i = 0; i < mdl_fill; i++)
                    line_expect.push_back(mk_res(1'b1, mdl_store[i],
                                                 cle_pkg::LEN_W'(mdl_fill),
                                                 (i + 1 == mdl_fill)));
                n = mdl_fill + 1;
                mdl_fill = 0;
            end
        end
        else if (c == cle_pkg::CH_DEL || c == cle_pkg::CH_BS)
        begin
            // Erase echoes backspace, space, backspace when there is a byte to remove.
            if (mdl_fill != 0)
            begin
                mdl_fill--;
                line_expect.push_back(mk_res(1'b0, cle_pkg::CH_BS, '0, 1'b0));
                line_expect.push_back(mk_res(1'b0, cle_pkg::CH_SP, '0, 1'b0));
                line_expect.push_back(mk_res(1'b0, cle_pkg::CH_BS, '0, 1'b1));
                n = 3;
            end
        end
        else if (c >= cle_pkg::CH_SP && c <= cle_pkg::CH_TILDE && mdl_fill < line_cap())
        begin
            mdl_store[mdl_fill] = c;
            mdl_fill++;
            line_expect.push_back(mk_res(1'b0, c, '0, 1'b1));
            n = 1;
        end
        return n;
    endfunction

    // Sends one byte beat after a random gap and predicts on acceptance.
    task automatic send_byte(input logic [cle_pkg::BYTE_W-1:0] b, output int nres);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            rx_valid <= 1'b0;
            @(posedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (!rx_ready);
        nres = predict_edit(b);
    endtask

    // Holds the sender off until every expected beat has come out.
    task automatic wait_drained();
        rx_valid <= 1'b0;
        do
            @(posedge clk);
        while (line_expect.size() != 0);
    endtask

    // Writes the line limit while the block is idle.
    task automatic write_limit(input logic [cle_pkg::LIMIT_W-1:0] v);
        wait_drained();
        repeat (SETTLE) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        mdl_limit = v;
    endtask

    // Output checker and random receiver stalls.
    always @(posedge clk)
    begin : out_side
        res_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (line_expect.size() == 0)
            begin
                $error("unexpected beat: dest %0d data %02h len %0d last %0d",
                       dest, data_byte, line_length, last);
                err_count++;
            end
            else
            begin
                want = line_expect.pop_front();
                if (dest !== want.dest)
                begin
                    $error("dest: expected %0d, actual %0d", want.dest, dest);
                    err_count++;
                end
                if (data_byte !== want.data)
                begin
                    $error("data_byte: expected %02h, actual %02h", want.data, data_byte);
                    err_count++;
                end
                if (line_length !== want.len)
                begin
                    $error("line_length: expected %0d, actual %0d", want.len, line_length);
                    err_count++;
                end
                if (last !== want.last)
                begin
                    $error("last: expected %0d, actual %0d", want.last, last);
                    err_count++;
                end
            end
        end
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Main sequence: reset, directed table, random phases, drain.
    initial
    begin : main
        row_t                        r;
        res_t                        none;
        int                          nres;
        int                          sent;
        int                          line_left;
        logic [cle_pkg::BYTE_W-1:0]  b;
        logic [cle_pkg::LIMIT_W-1:0] lim;

        none = '0;

        // Directed rows: line ends and erases on an empty line, dropped non-printable bytes,
        // printable extremes, erase, lowered limits, a limit of zero and a limit above the depth.
        stim_table.push_back(mk_row(ROW_FIXED, cle_pkg::CH_CR, 2'd0, none, none, none));
        stim_table.push_back(mk_row(ROW_FIXED, cle_pkg::CH_LF, 2'd0, none, none, none));
        stim_table.push_back(mk_row(ROW_FIXED, cle_pkg::CH_BS, 2'd0, none, none, none));
        stim_table.push_back(mk_row(ROW_FIXED, cle_pkg::CH_DEL, 2'd0, none, none, none));
        stim_table.push_back(mk_row(ROW_FIXED, 8'h00, 2'd0, none, none, none));
        stim_table.push_back(mk_row(ROW_FIXED, 8'hFF, 2'd0, none, none, none));
        stim_table.push_back(mk_row(ROW_FIXED, 8'h1F, 2'd0, none, none, none));
        stim_table.push_back(mk_row(ROW_FIXED, 8'h80, 2'd0, none, none, none));
        stim_table.push_back(mk_row(ROW_FIXED, cle_pkg::CH_SP, 2'd1,
                                    mk_res(1'b0, cle_pkg::CH_SP, '0, 1'b1), none, none));
        stim_table.push_back(mk_row(ROW_FIXED, cle_pkg::CH_TILDE, 2'd1,
                                    mk_res(1'b0, cle_pkg::CH_TILDE, '0, 1'b1), none, none));
        stim_table.push_back(mk_row(ROW_FIXED, cle_pkg::CH_DEL, 2'd3,
                                    mk_res(1'b0, cle_pkg::CH_BS, '0, 1'b0),
                                    mk_res(1'b0, cle_pkg::CH_SP, '0, 1'b0),
                                    mk_res(1'b0, cle_pkg::CH_BS, '0, 1'b1)));
        stim_table.push_back(mk_row(ROW_PRED, 8'h41, 2'd0, none, none, none));
        stim_table.push_back(mk_row(ROW_PRED, cle_pkg::CH_CR, 2'd0, none, none, none));
        stim_table.push_back(mk_row(ROW_CFG, 8'd1, 2'd0, none, none, none));
        stim_table.push_back(mk_row(ROW_FIXED, 8'h41, 2'd0, none, none, none));
        stim_table.push_back(mk_row(ROW_CFG, 8'd0, 2'd0, none, none, none));
        stim_table.push_back(mk_row(ROW_FIXED, 8'h42, 2'd0, none, none, none));
        stim_table.push_back(mk_row(ROW_CFG, 8'd3, 2'd0, none, none, none));
        stim_table.push_back(mk_row(ROW_PRED, 8'h61, 2'd0, none, none, none));
        stim_table.push_back(mk_row(ROW_PRED, 8'h62, 2'd0, none, none, none));
        stim_table.push_back(mk_row(ROW_PRED, 8'h63, 2'd0, none, none, none));
        stim_table.push_back(mk_row(ROW_CFG, 8'd2, 2'd0, none, none, none));
        stim_table.push_back(mk_row(ROW_PRED, 8'h64, 2'd0, none, none, none));
        stim_table.push_back(mk_row(ROW_PRED, cle_pkg::CH_BS, 2'd0, none, none, none));
        stim_table.push_back(mk_row(ROW_PRED, 8'h65, 2'd0, none, none, none));
        stim_table.push_back(mk_row(ROW_PRED, cle_pkg::CH_DEL, 2'd0, none, none, none));
        stim_table.push_back(mk_row(ROW_PRED, 8'h66, 2'd0, none, none, none));
        stim_table.push_back(mk_row(ROW_PRED, cle_pkg::CH_LF, 2'd0, none, none, none));
        stim_table.push_back(mk_row(ROW_CFG, 8'd127, 2'd0, none, none, none));
        stim_table.push_back(mk_row(ROW_PRED, 8'h7A, 2'd0, none, none, none));
        stim_table.push_back(mk_row(ROW_PRED, cle_pkg::CH_CR, 2'd0, none, none, none));
        stim_table.push_back(mk_row(ROW_CFG, 8'd64, 2'd0, none, none, none));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, no idling on either side.
        foreach (stim_table[i])
        begin
            r = stim_table[i];
            unique case (r.kind)
                ROW_CFG:
                    write_limit(r.val[cle_pkg::LIMIT_W-1:0]);
                ROW_FIXED:
                begin
                    // Keep the model state, but check against the typed-in beats.
                    send_byte(r.val, nres);
                    repeat (nres) void'(line_expect.pop_back());
                    if (r.nfix > 0)
                        line_expect.push_back(r.fx0);
                    if (r.nfix > 1)
                        line_expect.push_back(r.fx1);
                    if (r.nfix > 2)
                        line_expect.push_back(r.fx2);
                end
                default:
                    send_byte(r.val, nres);
            endcase
        end

        // Random phases: mostly typed lines with edits, some noise bytes.
        line_left = 5;
        for (int ph = 0; ph < 4; ph++)
        begin
            unique case (ph)
                0:
                begin
                    gap_pct = 0;  stall_pct = 0;
                    lim = cle_pkg::LIMIT_W'(64);
                end
                1:
                begin
                    gap_pct = 64; stall_pct = 0;
                    lim = cle_pkg::LIMIT_W'(127);
                end
                2:
                begin
                    gap_pct = 0;  stall_pct = 64;
                    lim = cle_pkg::LIMIT_W'($urandom_range(2, 12));
                end
                default:
                begin
                    gap_pct = 16; stall_pct = 16;
                    lim = cle_pkg::LIMIT_W'($urandom_range(2, 127));
                end
            endcase
            write_limit(lim);
            for (sent = 0; sent < PHASE_BEATS; sent++)
            begin
                if ($urandom_range(0, 99) < 8)
                    b = cle_pkg::BYTE_W'($urandom);
                else if (line_left == 0)
                begin
                    b = $urandom_range(0, 1) ? cle_pkg::CH_CR : cle_pkg::CH_LF;
                    if ($urandom_range(0, 9) == 0)
                        line_left = $urandom_range(40, 70);
                    else
                        line_left = $urandom_range(1, 12);
                end
                else if ($urandom_range(0, 99) < 10)
                    b = $urandom_range(0, 1) ? cle_pkg::CH_BS : cle_pkg::CH_DEL;
                else
                begin
                    b = cle_pkg::BYTE_W'($urandom_range(32, 126));
                    line_left--;
                end
                // Now and then the sender waits for the output side to drain.
                if ($urandom_range(0, 39) == 0)
                    wait_drained();
                send_byte(b, nres);
            end
        end

        // Drain and report.
        wait_drained();
        repeat (2 * SETTLE) @(posedge clk);
        if (err_count == 0)
            $display("[console_line_editor] OK");
        else
            $display("[console_line_editor] ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
src/cle_pkg.sv
src/cle_line_ram.sv
src/console_line_editor.sv
tb/tb_console_line_editor.sv
